// ===== sv/radio_link_failure_monitor_defines.svh =====
// assertion macros shared by the radio link failure monitor checks
`ifndef RADIO_LINK_FAILURE_MONITOR_DEFINES_SVH
`define RADIO_LINK_FAILURE_MONITOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RLFM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define RLFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rlfm_pkg.sv =====
// types and constants of the radio link failure monitor
package rlfm_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_Q_OUT      = 3'd1;
	localparam logic [2:0] REG_Q_IN       = 3'd2;
	localparam logic [2:0] REG_OOS_NEED   = 3'd3;
	localparam logic [2:0] REG_INS_NEED   = 3'd4;
	localparam logic [2:0] REG_T310_TICKS = 3'd5;
	localparam logic [2:0] REG_WD_TICKS   = 3'd6;

	// item kinds
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_BEACON = 1'b1;

	// failure causes
	typedef enum logic [1:0] {
		CAUSE_NONE      = 2'd0,
		CAUSE_T310      = 2'd1,
		CAUSE_LOSS      = 2'd2,
		CAUSE_NO_BEACON = 2'd3
	} cause_t;

	// register reset values
	localparam logic signed [11:0] Q_OUT_RESET      = -12'sd64;
	localparam logic signed [11:0] Q_IN_RESET       = -12'sd48;
	localparam logic [7:0]         OOS_NEED_RESET   = 8'd1;
	localparam logic [7:0]         INS_NEED_RESET   = 8'd1;
	localparam logic [15:0]        T310_TICKS_RESET = 16'd1000;
	localparam logic [15:0]        WD_TICKS_RESET   = 16'd1000;

	localparam logic [7:0] CNT_MAX = 8'd255;

	// link monitoring state
	typedef struct packed {
		logic [15:0] mon_cell;
		logic        mon_valid;
		logic [7:0]  oos_cnt;
		logic [7:0]  ins_cnt;
		logic        fail;
		logic [15:0] t310_left;
		logic        t310_act;
		logic [15:0] wd_left;
		logic        wd_act;
		logic        seen;
	} rlfm_state_t;

endpackage

// ===== sv/radio_link_failure_monitor.sv =====
// radio link failure monitor: out-of-sync / in-sync counting, T310 and beacon watchdog
//
// Each input word is a time tick or a serving-cell beacon and gives exactly one
// result word. The block takes one word per clock cycle while in_stall is low; a word is
// registered on entry, evaluated combinationally against the monitoring state and its result
// is loaded into an output register when the word advances; that register holds
// while out_stall is high. A beacon from a new cell clears the counters, the failure flag and T310;
// T310 and the watchdog count down on ticks only. Configuration is written through
// cfg_we / cfg_index / cfg_data and takes effect at once; write it only while no
// word is in flight. There is no clearing pass after reset.
module radio_link_failure_monitor (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [15:0]        cell_id,
	input  logic               cell_valid,
	input  logic signed [11:0] rssi,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic               failure_pulse,
	output logic [1:0]         failure_cause,
	output logic [15:0]        failure_cell,
	output logic               failure_active,
	output logic               t310_running,
	output logic               recovered_pulse,
	output logic [7:0]         oos_count,
	output logic [7:0]         insync_count
);

	// configuration registers
	logic               enable_q;
	logic signed [11:0] q_out_q;
	logic signed [11:0] q_in_q;
	logic [7:0]         oos_need_q;
	logic [7:0]         ins_need_q;
	logic [15:0]        t310_ticks_q;
	logic [15:0]        wd_ticks_q;

	// input stage
	logic               valid_s1;
	logic               func_s1;
	logic [15:0]        cell_s1;
	logic               cvalid_s1;
	logic signed [11:0] rssi_s1;

	// state and next state
	rlfm_pkg::rlfm_state_t st_q;
	rlfm_pkg::rlfm_state_t st_d;

	// result evaluation
	logic             pulse_d;
	rlfm_pkg::cause_t cause_d;
	logic [15:0]      fcell_d;
	logic             rec_d;

	// output register
	logic             out_valid_q;
	logic             pulse_q;
	rlfm_pkg::cause_t cause_q;
	logic [15:0]      fcell_q;
	logic             active_q;
	logic             t310_q;
	logic             rec_q;
	logic [7:0]       oos_q;
	logic [7:0]       ins_q;

	logic advance;
	logic accept;

	// handshake: the input stage moves on whenever the output slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b1;
			q_out_q      <= rlfm_pkg::Q_OUT_RESET;
			q_in_q       <= rlfm_pkg::Q_IN_RESET;
			oos_need_q   <= rlfm_pkg::OOS_NEED_RESET;
			ins_need_q   <= rlfm_pkg::INS_NEED_RESET;
			t310_ticks_q <= rlfm_pkg::T310_TICKS_RESET;
			wd_ticks_q   <= rlfm_pkg::WD_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlfm_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
				rlfm_pkg::REG_Q_OUT:      q_out_q      <= signed'(cfg_data[11:0]);
				rlfm_pkg::REG_Q_IN:       q_in_q       <= signed'(cfg_data[11:0]);
				rlfm_pkg::REG_OOS_NEED:   oos_need_q   <= cfg_data[7:0];
				rlfm_pkg::REG_INS_NEED:   ins_need_q   <= cfg_data[7:0];
				rlfm_pkg::REG_T310_TICKS: t310_ticks_q <= cfg_data;
				rlfm_pkg::REG_WD_TICKS:   wd_ticks_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			cell_s1   <= cell_id;
			cvalid_s1 <= cell_valid;
			rssi_s1   <= rssi;
		end
	end

	// evaluate one word against the monitoring state
	always_comb begin
		logic same;
		logic t_exp;
		logic w_exp;
		st_d    = st_q;
		pulse_d = 1'b0;
		cause_d = rlfm_pkg::CAUSE_NONE;
		fcell_d = '0;
		rec_d   = 1'b0;
		same    = cvalid_s1 && st_q.mon_valid && (cell_s1 == st_q.mon_cell);
		t_exp   = 1'b0;
		w_exp   = 1'b0;
		if (enable_q && (func_s1 == rlfm_pkg::FUNC_BEACON) && cvalid_s1) begin
			st_d.seen = 1'b1;
			// new cell: start monitoring from scratch
			if (!st_q.mon_valid || (st_q.mon_cell != cell_s1)) begin
				st_d.oos_cnt   = '0;
				st_d.ins_cnt   = '0;
				st_d.fail      = 1'b0;
				st_d.t310_act  = 1'b0;
				st_d.t310_left = '0;
				st_d.mon_cell  = cell_s1;
				st_d.mon_valid = 1'b1;
			end
			st_d.wd_left = wd_ticks_q;
			st_d.wd_act  = 1'b1;
			priority if (st_d.fail) begin
				// recovery needs an in-sync level
				if (rssi_s1 >= q_in_q) begin
					st_d.fail    = 1'b0;
					st_d.oos_cnt = '0;
					st_d.ins_cnt = '0;
					rec_d        = 1'b1;
				end
			end else if (rssi_s1 < q_out_q) begin
				// out of sync
				st_d.ins_cnt = '0;
				if (st_d.oos_cnt != rlfm_pkg::CNT_MAX) begin
					st_d.oos_cnt = st_d.oos_cnt + 8'd1;
				end
				if ((st_d.oos_cnt >= oos_need_q) && !st_d.t310_act) begin
					st_d.t310_act  = 1'b1;
					st_d.t310_left = t310_ticks_q;
				end
			end else if (rssi_s1 >= q_in_q) begin
				// in sync
				st_d.oos_cnt = '0;
				if (st_d.t310_act) begin
					if (st_d.ins_cnt != rlfm_pkg::CNT_MAX) begin
						st_d.ins_cnt = st_d.ins_cnt + 8'd1;
					end
					if (st_d.ins_cnt >= ins_need_q) begin
						st_d.t310_act  = 1'b0;
						st_d.t310_left = '0;
						st_d.ins_cnt   = '0;
					end
				end
			end else begin
				// between thresholds: no change
			end
		end else if (enable_q && (func_s1 == rlfm_pkg::FUNC_TICK)) begin
			// timers count down together
			if (st_q.t310_act) begin
				t_exp          = (st_q.t310_left <= 16'd1);
				st_d.t310_left = t_exp ? 16'd0 : st_q.t310_left - 16'd1;
			end
			if (st_q.wd_act) begin
				w_exp        = (st_q.wd_left <= 16'd1);
				st_d.wd_left = w_exp ? 16'd0 : st_q.wd_left - 16'd1;
			end
			// T310 expiry is handled first
			if (t_exp) begin
				st_d.oos_cnt   = '0;
				st_d.ins_cnt   = '0;
				st_d.t310_act  = 1'b0;
				st_d.t310_left = '0;
				st_d.fail      = same;
				if (same) begin
					pulse_d = 1'b1;
					cause_d = rlfm_pkg::CAUSE_T310;
					fcell_d = cell_s1;
				end
			end
			if (w_exp) begin
				st_d.wd_act = 1'b0;
				priority if (!st_q.seen) begin
					cause_d = rlfm_pkg::CAUSE_NO_BEACON;
					fcell_d = cvalid_s1 ? cell_s1 : 16'd0;
				end else if (!st_d.fail && same) begin
					st_d.fail      = 1'b1;
					st_d.oos_cnt   = '0;
					st_d.ins_cnt   = '0;
					st_d.t310_act  = 1'b0;
					st_d.t310_left = '0;
					pulse_d        = 1'b1;
					cause_d        = rlfm_pkg::CAUSE_LOSS;
					fcell_d        = cell_s1;
				end else begin
					// failure already flagged or serving cell changed
				end
			end
		end
	end

	// monitoring state, watchdog re-armed by a duration write before any beacon
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{wd_left: rlfm_pkg::WD_TICKS_RESET, wd_act: 1'b1, default: '0};
		end else if (advance) begin
			st_q <= st_d;
		end else if (cfg_we && (cfg_index == rlfm_pkg::REG_WD_TICKS) && !st_q.seen
				&& st_q.wd_act) begin
			st_q.wd_left <= cfg_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q  <= pulse_d;
			cause_q  <= cause_d;
			fcell_q  <= fcell_d;
			active_q <= st_d.fail;
			t310_q   <= st_d.t310_act;
			rec_q    <= rec_d;
			oos_q    <= st_d.oos_cnt;
			ins_q    <= st_d.ins_cnt;
		end
	end

	assign out_valid       = out_valid_q;
	assign failure_pulse   = pulse_q;
	assign failure_cause   = cause_q;
	assign failure_cell    = fcell_q;
	assign failure_active  = active_q;
	assign t310_running    = t310_q;
	assign recovered_pulse = rec_q;
	assign oos_count       = oos_q;
	assign insync_count    = ins_q;

endmodule

// ===== sv/rlfm_checker.sv =====
// port-level checks of the radio link failure monitor, bound to the top level
`include "radio_link_failure_monitor_defines.svh"

module rlfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        failure_pulse,
	input logic [1:0]  failure_cause,
	input logic [15:0] failure_cell,
	input logic        failure_active,
	input logic        t310_running,
	input logic        recovered_pulse,
	input logic [7:0]  oos_count,
	input logic [7:0]  insync_count
);

	// a declared failure sets the flag and names a real cause
	`RLFM_ASSERT_NOW(a_pulse_cause, clk, arst_n, out_valid && failure_pulse, failure_active && ((failure_cause == rlfm_pkg::CAUSE_T310) || (failure_cause == rlfm_pkg::CAUSE_LOSS)), "failure word without flag or cause")

	// declaring failure stops T310 and clears both counters
	`RLFM_ASSERT_NOW(a_pulse_clears, clk, arst_n, out_valid && failure_pulse, !t310_running && (oos_count == 8'd0) && (insync_count == 8'd0), "failure left timer or counters set")

	// recovery clears the flag and never coincides with a failure
	`RLFM_ASSERT_NOW(a_recovery, clk, arst_n, out_valid && recovered_pulse, !failure_active && !failure_pulse && (oos_count == 8'd0) && (insync_count == 8'd0), "inconsistent recovery word")

	// a stalled result word holds
	`RLFM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(failure_cell) && $stable(failure_cause) && $stable(oos_count), "stalled result word changed")

endmodule

bind radio_link_failure_monitor rlfm_checker u_rlfm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.failure_pulse   (failure_pulse),
	.failure_cause   (failure_cause),
	.failure_cell    (failure_cell),
	.failure_active  (failure_active),
	.t310_running    (t310_running),
	.recovered_pulse (recovered_pulse),
	.oos_count       (oos_count),
	.insync_count    (insync_count)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the radio link failure monitor with a built-in link state predictor
module testbench;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned END_CYCLES    = 10;
	localparam int unsigned MAX_GAP       = 13;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned HOLD_CYCLES   = 150;

	localparam logic signed [11:0] RSSI_MIN = 12'sh800;
	localparam logic signed [11:0] RSSI_MAX = 12'sh7FF;

	typedef struct {
		logic               enable;
		logic signed [11:0] q_out;
		logic signed [11:0] q_in;
		logic [7:0]         oos_need;
		logic [7:0]         ins_need;
		logic [15:0]        t310_ticks;
		logic [15:0]        wd_ticks;
	} link_cfg_t;

	typedef struct {
		logic             pulse;
		rlfm_pkg::cause_t cause;
		logic [15:0]      fail_cell;
		logic             active;
		logic             t310;
		logic             recovered;
		logic [7:0]       oos;
		logic [7:0]       ins;
	} link_report_t;

	typedef enum int unsigned {TREND_BAD, TREND_GOOD, TREND_MIXED, TREND_SILENT} trend_t;

	// block ports
	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [15:0]        cell_id;
	logic               cell_valid;
	logic signed [11:0] rssi;
	logic               out_valid;
	logic               out_stall;
	logic               failure_pulse;
	logic [1:0]         failure_cause;
	logic [15:0]        failure_cell;
	logic               failure_active;
	logic               t310_running;
	logic               recovered_pulse;
	logic [7:0]         oos_count;
	logic [7:0]         insync_count;

	// predicted link state and register copy
	link_cfg_t    cfg_now;
	logic [15:0]  lk_cell;
	logic         lk_cell_ok;
	logic [7:0]   lk_oos;
	logic [7:0]   lk_ins;
	logic         lk_fail;
	logic [15:0]  lk_t310_left;
	logic         lk_t310_on;
	logic [15:0]  lk_wd_left;
	logic         lk_wd_on;
	logic         lk_seen;
	link_report_t due_reports[$];

	// pacing and bookkeeping
	bit           src_calm;
	bit           sink_calm;
	int unsigned  hold_left;
	int unsigned  cycle_count;
	int unsigned  mismatches;
	int unsigned  n_words;
	int unsigned  n_checked;
	int unsigned  n_settings;
	int unsigned  n_failures;
	int unsigned  n_recoveries;
	int unsigned  n_no_beacon;
	logic [15:0]  cell_pool [4];
	logic [15:0]  serving;

	radio_link_failure_monitor i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.cell_id         (cell_id),
		.cell_valid      (cell_valid),
		.rssi            (rssi),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.failure_pulse   (failure_pulse),
		.failure_cause   (failure_cause),
		.failure_cell    (failure_cell),
		.failure_active  (failure_active),
		.t310_running    (t310_running),
		.recovered_pulse (recovered_pulse),
		.oos_count       (oos_count),
		.insync_count    (insync_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic link_cfg_t default_config();
		link_cfg_t c;
		c.enable     = 1'b1;
		c.q_out      = rlfm_pkg::Q_OUT_RESET;
		c.q_in       = rlfm_pkg::Q_IN_RESET;
		c.oos_need   = rlfm_pkg::OOS_NEED_RESET;
		c.ins_need   = rlfm_pkg::INS_NEED_RESET;
		c.t310_ticks = rlfm_pkg::T310_TICKS_RESET;
		c.wd_ticks   = rlfm_pkg::WD_TICKS_RESET;
		return c;
	endfunction

	function automatic link_cfg_t draw_config();
		link_cfg_t c;
		int q;
		q = int'($urandom_range(0, 400)) - 300;
		c.enable     = 1'b1;
		c.q_out      = 12'(q);
		c.q_in       = 12'(q + int'($urandom_range(0, 60)));
		c.oos_need   = 8'($urandom_range(1, 5));
		c.ins_need   = 8'($urandom_range(1, 5));
		c.t310_ticks = 16'($urandom_range(1, 24));
		c.wd_ticks   = 16'($urandom_range(4, 48));
		return c;
	endfunction

	// counters, flag and T310 back to idle
	function automatic void clear_link();
		lk_oos       = 8'd0;
		lk_ins       = 8'd0;
		lk_fail      = 1'b0;
		lk_t310_on   = 1'b0;
		lk_t310_left = 16'd0;
	endfunction

	// link state update for one accepted word, queues the report it should give
	function automatic void advance_monitor(input logic f, input logic [15:0] c, input logic cv,
			input logic signed [11:0] r);
		link_report_t rep;
		logic same;
		logic t_out;
		logic w_out;
		rep.pulse     = 1'b0;
		rep.cause     = rlfm_pkg::CAUSE_NONE;
		rep.fail_cell = 16'd0;
		rep.recovered = 1'b0;
		if (cfg_now.enable && f == rlfm_pkg::FUNC_BEACON && cv) begin
			lk_seen = 1'b1;
			// a beacon from another cell restarts monitoring
			if (!lk_cell_ok || lk_cell != c) begin
				clear_link();
				lk_cell    = c;
				lk_cell_ok = 1'b1;
			end
			lk_wd_left = cfg_now.wd_ticks;
			lk_wd_on   = 1'b1;
			if (lk_fail) begin
				if (r >= cfg_now.q_in) begin
					lk_fail       = 1'b0;
					lk_oos        = 8'd0;
					lk_ins        = 8'd0;
					rep.recovered = 1'b1;
				end
			end else if (r < cfg_now.q_out) begin
				lk_ins = 8'd0;
				if (lk_oos != rlfm_pkg::CNT_MAX)
					lk_oos = lk_oos + 8'd1;
				if (lk_oos >= cfg_now.oos_need && !lk_t310_on) begin
					lk_t310_on   = 1'b1;
					lk_t310_left = cfg_now.t310_ticks;
				end
			end else if (r >= cfg_now.q_in) begin
				lk_oos = 8'd0;
				if (lk_t310_on) begin
					if (lk_ins != rlfm_pkg::CNT_MAX)
						lk_ins = lk_ins + 8'd1;
					if (lk_ins >= cfg_now.ins_need) begin
						lk_t310_on   = 1'b0;
						lk_t310_left = 16'd0;
						lk_ins       = 8'd0;
					end
				end
			end
		end else if (cfg_now.enable && f == rlfm_pkg::FUNC_TICK) begin
			same  = cv && lk_cell_ok && (c == lk_cell);
			t_out = 1'b0;
			w_out = 1'b0;
			// both timers count down on the same tick
			if (lk_t310_on) begin
				if (lk_t310_left <= 16'd1) begin
					lk_t310_left = 16'd0;
					t_out        = 1'b1;
				end else
					lk_t310_left = lk_t310_left - 16'd1;
			end
			if (lk_wd_on) begin
				if (lk_wd_left <= 16'd1) begin
					lk_wd_left = 16'd0;
					w_out      = 1'b1;
				end else
					lk_wd_left = lk_wd_left - 16'd1;
			end
			// T310 first, then the watchdog
			if (t_out) begin
				clear_link();
				if (same) begin
					lk_fail       = 1'b1;
					rep.pulse     = 1'b1;
					rep.cause     = rlfm_pkg::CAUSE_T310;
					rep.fail_cell = c;
				end
			end
			if (w_out) begin
				lk_wd_on = 1'b0;
				if (!lk_seen) begin
					rep.cause     = rlfm_pkg::CAUSE_NO_BEACON;
					rep.fail_cell = cv ? c : 16'd0;
				end else if (!lk_fail && same) begin
					clear_link();
					lk_fail       = 1'b1;
					rep.pulse     = 1'b1;
					rep.cause     = rlfm_pkg::CAUSE_LOSS;
					rep.fail_cell = c;
				end
			end
		end
		rep.active = lk_fail;
		rep.t310   = lk_t310_on;
		rep.oos    = lk_oos;
		rep.ins    = lk_ins;
		if (rep.pulse)
			n_failures++;
		if (rep.recovered)
			n_recoveries++;
		if (rep.cause == rlfm_pkg::CAUSE_NO_BEACON)
			n_no_beacon++;
		due_reports.push_back(rep);
	endfunction

	// wait until every queued report has come back and the pipeline is quiet
	task automatic drain_words();
		in_valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, mirrored into the predictor copy
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			rlfm_pkg::REG_ENABLE:     cfg_now.enable     = data[0];
			rlfm_pkg::REG_Q_OUT:      cfg_now.q_out      = data[11:0];
			rlfm_pkg::REG_Q_IN:       cfg_now.q_in       = data[11:0];
			rlfm_pkg::REG_OOS_NEED:   cfg_now.oos_need   = data[7:0];
			rlfm_pkg::REG_INS_NEED:   cfg_now.ins_need   = data[7:0];
			rlfm_pkg::REG_T310_TICKS: cfg_now.t310_ticks = data;
			rlfm_pkg::REG_WD_TICKS: begin
				cfg_now.wd_ticks = data;
				// an armed watchdog that has never seen a beacon takes the new length
				if (!lk_seen && lk_wd_on)
					lk_wd_left = data;
			end
			default: ;
		endcase
	endtask

	// full register set, written only once the block is idle
	task automatic set_config(input link_cfg_t c);
		drain_words();
		write_reg(rlfm_pkg::REG_ENABLE, {15'd0, c.enable});
		write_reg(rlfm_pkg::REG_Q_OUT, {{4{c.q_out[11]}}, c.q_out});
		write_reg(rlfm_pkg::REG_Q_IN, {{4{c.q_in[11]}}, c.q_in});
		write_reg(rlfm_pkg::REG_OOS_NEED, {8'd0, c.oos_need});
		write_reg(rlfm_pkg::REG_INS_NEED, {8'd0, c.ins_need});
		write_reg(rlfm_pkg::REG_T310_TICKS, c.t310_ticks);
		write_reg(rlfm_pkg::REG_WD_TICKS, c.wd_ticks);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// offer one word after a random gap and wait for it to be taken
	task automatic send_word(input logic f, input logic [15:0] c, input logic cv,
			input logic signed [11:0] r);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		cell_id    <= c;
		cell_valid <= cv;
		rssi       <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_monitor(f, c, cv, r);
		n_words++;
	endtask

	// random words around the serving cell, with RSSI steered by a drifting trend
	task automatic run_traffic(input int unsigned count, input bit vary_pace);
		trend_t      trend;
		logic [15:0] c;
		logic        cv;
		int unsigned beacon_pct;
		int          lo;
		int          hi;
		int          v;
		trend = TREND_MIXED;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0)
				serving = cell_pool[$urandom_range(0, 3)];
			if ($urandom_range(0, 11) == 0)
				trend = trend_t'($urandom_range(0, 3));
			if (vary_pace && $urandom_range(0, 39) == 0) begin
				src_calm  = ($urandom_range(0, 2) == 0);
				sink_calm = ($urandom_range(0, 2) == 0);
			end
			beacon_pct = (trend == TREND_SILENT) ? 8 : 50;
			if ($urandom_range(0, 99) < beacon_pct) begin
				c  = ($urandom_range(0, 9) == 0) ? cell_pool[$urandom_range(0, 3)] : serving;
				cv = ($urandom_range(0, 19) != 0);
				lo = cfg_now.q_out;
				hi = cfg_now.q_in;
				// threshold edges, full range, or the current trend
				case ($urandom_range(0, 11))
					0: v = lo;
					1: v = lo - 1;
					2: v = hi;
					3: v = hi - 1;
					4: v = int'($urandom_range(0, 4095)) - 2048;
					default: begin
						case (trend)
							TREND_BAD:  v = lo - 1 - int'($urandom_range(0, 40));
							TREND_GOOD: v = hi + int'($urandom_range(0, 40));
							default:    v = lo + int'($urandom_range(0, 60)) - 30;
						endcase
					end
				endcase
				if (v < -2048)
					v = -2048;
				if (v > 2047)
					v = 2047;
				send_word(rlfm_pkg::FUNC_BEACON, c, cv, 12'(v));
			end else begin
				c  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : serving;
				cv = ($urandom_range(0, 9) != 0);
				send_word(rlfm_pkg::FUNC_TICK, c, cv, 12'($urandom()));
			end
		end
	endtask

	// hand-picked words for each corner of the link monitoring rules
	task automatic test_directed();
		link_cfg_t c;
		c = default_config();
		// watchdog shortened before any beacon, runs out on the third tick
		c.wd_ticks = 16'd3;
		set_config(c);
		send_word(rlfm_pkg::FUNC_TICK, 16'h0005, 1'b0, 12'sd0);
		send_word(rlfm_pkg::FUNC_TICK, 16'h0005, 1'b1, RSSI_MIN);
		send_word(rlfm_pkg::FUNC_TICK, 16'hFFFF, 1'b1, RSSI_MAX);
		// beacon without a serving cell is ignored
		send_word(rlfm_pkg::FUNC_BEACON, 16'hFFFF, 1'b0, RSSI_MIN);
		send_word(rlfm_pkg::FUNC_BEACON, 16'hFFFF, 1'b1, RSSI_MAX);
		// zero-length T310 runs out on the next tick
		c.t310_ticks = 16'd0;
		c.wd_ticks   = 16'hFFFF;
		set_config(c);
		send_word(rlfm_pkg::FUNC_BEACON, 16'hFFFF, 1'b1, RSSI_MIN);
		send_word(rlfm_pkg::FUNC_TICK, 16'hFFFF, 1'b1, 12'sd0);
		// recovery at exactly q_in
		send_word(rlfm_pkg::FUNC_BEACON, 16'hFFFF, 1'b1, rlfm_pkg::Q_IN_RESET);
		// q_out itself is not out of sync, one below is
		send_word(rlfm_pkg::FUNC_BEACON, 16'hFFFF, 1'b1, rlfm_pkg::Q_OUT_RESET);
		send_word(rlfm_pkg::FUNC_BEACON, 16'hFFFF, 1'b1, rlfm_pkg::Q_OUT_RESET - 12'sd1);
		// T310 runs out while another cell serves
		send_word(rlfm_pkg::FUNC_TICK, 16'h1234, 1'b1, 12'sd0);
		// new cell restarts monitoring, then in-sync stops T310
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, rlfm_pkg::Q_OUT_RESET - 12'sd1);
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, RSSI_MAX);
		// zero-length watchdog gives beacon loss on the next tick
		c.wd_ticks = 16'd0;
		set_config(c);
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, -12'sd56);
		send_word(rlfm_pkg::FUNC_TICK, 16'h0000, 1'b1, 12'sd0);
		// failed link ignores bad RSSI, good RSSI recovers
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, RSSI_MIN);
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, -12'sd40);
		// watchdog runs out with no serving cell: nothing declared
		send_word(rlfm_pkg::FUNC_TICK, 16'h0000, 1'b0, 12'sd0);
		// crossed thresholds: out of sync wins
		c.q_out      = 12'sd100;
		c.q_in       = -12'sd100;
		c.t310_ticks = rlfm_pkg::T310_TICKS_RESET;
		c.wd_ticks   = rlfm_pkg::WD_TICKS_RESET;
		set_config(c);
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, 12'sd0);
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, 12'sd100);
		// monitoring switched off
		c.enable = 1'b0;
		set_config(c);
		send_word(rlfm_pkg::FUNC_BEACON, 16'h0000, 1'b1, RSSI_MIN);
		send_word(rlfm_pkg::FUNC_TICK, 16'h0000, 1'b1, RSSI_MAX);
	endtask

	// long runs of bad then good beacons drive both counters to their limit
	task automatic test_counter_saturation();
		link_cfg_t c;
		c = default_config();
		c.oos_need   = rlfm_pkg::CNT_MAX;
		c.ins_need   = rlfm_pkg::CNT_MAX;
		c.t310_ticks = 16'hFFFF;
		c.wd_ticks   = 16'hFFFF;
		set_config(c);
		repeat (270)
			send_word(rlfm_pkg::FUNC_BEACON, 16'h2A5C, 1'b1,
				12'(-65 - int'($urandom_range(0, 1983))));
		repeat (265)
			send_word(rlfm_pkg::FUNC_BEACON, 16'h2A5C, 1'b1,
				12'(-48 + int'($urandom_range(0, 2095))));
	endtask

	// random traffic over several register settings, extremes among them
	task automatic test_random_traffic();
		link_cfg_t c;
		for (int p = 0; p < 6; p++) begin
			c = draw_config();
			case (p)
				1: begin
					c.q_out = RSSI_MIN;
					c.q_in  = RSSI_MAX;
				end
				2: begin
					c.q_out = RSSI_MAX;
					c.q_in  = RSSI_MIN;
				end
				3: begin
					c.oos_need   = rlfm_pkg::CNT_MAX;
					c.ins_need   = rlfm_pkg::CNT_MAX;
					c.t310_ticks = 16'hFFFF;
					c.wd_ticks   = 16'hFFFF;
				end
				4: c.q_in = c.q_out - 12'sd20;
				default: ;
			endcase
			set_config(c);
			run_traffic(200, 1'b1);
		end
		src_calm  = 1'b0;
		sink_calm = 1'b0;
	endtask

	// receiver holds off while words keep coming, so the block backs up
	task automatic test_output_hold();
		set_config(draw_config());
		src_calm  = 1'b1;
		hold_left = HOLD_CYCLES;
		run_traffic(60, 1'b0);
		src_calm  = 1'b0;
	endtask

	// receiver: random stall after each word, plus the long hold-off
	initial begin : result_sink
		int unsigned wait_left;
		logic        stall_next;
		wait_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left  = hold_left - 1;
				stall_next = 1'b1;
			end else begin
				if (out_valid && !out_stall)
					wait_left = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
				if (wait_left != 0) begin
					wait_left  = wait_left - 1;
					stall_next = 1'b1;
				end else
					stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch in %s of result %0d: expected %0d, got %0d",
					name, n_checked, want, got);
		end
	endfunction

	// compare each accepted result with the oldest queued report
	always @(posedge clk) begin : result_check
		link_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result word with nothing pending, cause %0d cell %0d",
						failure_cause, failure_cell);
			end else begin
				want = due_reports.pop_front();
				check_field("failure_pulse", 16'(want.pulse), 16'(failure_pulse));
				check_field("failure_cause", 16'(want.cause), 16'(failure_cause));
				check_field("failure_cell", want.fail_cell, failure_cell);
				check_field("failure_active", 16'(want.active), 16'(failure_active));
				check_field("t310_running", 16'(want.t310), 16'(t310_running));
				check_field("recovered_pulse", 16'(want.recovered), 16'(recovered_pulse));
				check_field("oos_count", 16'(want.oos), 16'(oos_count));
				check_field("insync_count", 16'(want.ins), 16'(insync_count));
				n_checked++;
			end
		end
	end

	// run time guard
	initial begin : cycle_guard
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// reset, then the tests in turn
	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= rlfm_pkg::REG_ENABLE;
		cfg_data   <= 16'd0;
		in_valid   <= 1'b0;
		func       <= rlfm_pkg::FUNC_TICK;
		cell_id    <= 16'd0;
		cell_valid <= 1'b0;
		rssi       <= 12'sd0;
		src_calm     = 1'b0;
		sink_calm    = 1'b0;
		hold_left    = 0;
		mismatches   = 0;
		n_words      = 0;
		n_checked    = 0;
		n_settings   = 0;
		n_failures   = 0;
		n_recoveries = 0;
		n_no_beacon  = 0;
		cell_pool[0] = 16'h0000;
		cell_pool[1] = 16'hFFFF;
		cell_pool[2] = 16'($urandom());
		cell_pool[3] = 16'($urandom());
		serving      = cell_pool[2];
		// predictor state after reset
		cfg_now      = default_config();
		lk_cell      = 16'd0;
		lk_cell_ok   = 1'b0;
		clear_link();
		lk_wd_left   = cfg_now.wd_ticks;
		lk_wd_on     = 1'b1;
		lk_seen      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_counter_saturation();
		test_random_traffic();
		test_output_hold();

		drain_words();
		repeat (END_CYCLES) @(posedge clk);
		$display("%0d words over %0d register settings: %0d link failures, %0d recoveries,",
			n_words, n_settings, n_failures, n_recoveries);
		$display("%0d watchdog errors before any beacon, %0d results compared, %0d mismatches",
			n_no_beacon, n_checked, mismatches);
		if (mismatches == 0 && due_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
